@@ src/m3h_pkg.sv @@
// Shared types, constants and helper functions for the MurmurHash3 x86_32 key hasher.
// Used by the controller, the datapath, the top level and the port checker.
package m3h_pkg;

    localparam logic [31:0] MIX_C1       = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2       = 32'h1b873593;
    localparam logic [31:0] MIX_ADD      = 32'he6546b64;
    localparam logic [31:0] FIN_C1       = 32'h85ebca6b;
    localparam logic [31:0] FIN_C2       = 32'hc2b2ae35;
    localparam logic [31:0] DEFAULT_SEED = 32'hAA6F3B22;

    localparam logic [4:0]  INDEX_BITS_RESET = 5'd4;
    localparam int unsigned PADDR_W          = 3;

    // Register indexes on the configuration port (byte address bit 2).
    localparam logic REG_SEED       = 1'b0;
    localparam logic REG_INDEX_BITS = 1'b1;

    localparam logic [2:0] FULL_WORD = 3'd4;

    typedef struct packed {
        logic [31:0] key_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [31:0] hash_value;
        logic [30:0] bucket_index;
    } out_item_t;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL1,
        DP_MUL2,
        DP_MIX,
        DP_FIN1,
        DP_FIN2,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        return {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        return {x[18:0], x[31:19]};
    endfunction

    // Counts of 5 to 7 behave as a full word.
    function automatic logic [2:0] clamp_count(input logic [2:0] cnt);
        return (cnt > FULL_WORD) ? FULL_WORD : cnt;
    endfunction

    // Clears the bytes above the valid count; a full or empty word passes unchanged.
    function automatic logic [31:0] mask_word(input logic [31:0] w, input logic [2:0] cnt);
        logic [31:0] r;
        case (cnt)
            3'd1:    r = {24'd0, w[7:0]};
            3'd2:    r = {16'd0, w[15:0]};
            3'd3:    r = {8'd0, w[23:0]};
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

@@ src/murmur3_32_key_hash.sv @@
// MurmurHash3 x86_32 key hasher, top level: configuration registers and unit wiring.
// Depends on m3h_pkg, m3h_ctrl and m3h_dp.
//
// A key arrives as little-endian 32-bit words, one request per word, with a byte count
// and a last-word flag; the block returns one request per key carrying the hash and
// the hash masked to index_bits bits. A word that is not last steps through MUL1, MUL2
// and MIX before the next word can be taken. The last word of a key also steps through
// FIN1, FIN2 and EMIT until its result is loaded into the output register, and the
// next word can be taken in the cycle after the load. The load waits while the
// previous result is held and not taken. The single shared 32x32 multiplier forms the
// two scramble products of each word and the two finalizer products in turn. A
// finished result waits in the output register while the next key is being taken in.
// The seed is sampled when a key starts and index_bits when the result is loaded, so
// both must be written while the block is idle; the block does not enforce it.
module murmur3_32_key_hash (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  m3h_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output m3h_pkg::out_item_t                  m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [m3h_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import m3h_pkg::*;

    logic [31:0] seed_reg, seed_next;
    logic [4:0]  index_bits_reg, index_bits_next;
    logic        wr_en;
    dp_cmd_t     cmd;
    dp_status_t  status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        seed_next       = seed_reg;
        index_bits_next = index_bits_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_SEED:       seed_next       = pwdata;
                REG_INDEX_BITS: index_bits_next = pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SEED:       prdata = seed_reg;
            REG_INDEX_BITS: prdata = {27'd0, index_bits_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg       <= 32'd0;
            index_bits_reg <= INDEX_BITS_RESET;
        end else begin
            seed_reg       <= seed_next;
            index_bits_reg <= index_bits_next;
        end
    end

    m3h_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    m3h_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_data     (s_data),
        .seed       (seed_reg),
        .index_bits (index_bits_reg),
        .m_data     (m_data)
    );

endmodule

@@ src/m3h_ctrl.sv @@
// Sequencer for the MurmurHash3 key hasher: steps the datapath through mixing and finalizing.
// Depends on m3h_pkg for the command and status types.
module m3h_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output m3h_pkg::dp_cmd_t   cmd,
    input  m3h_pkg::dp_status_t status
);
    import m3h_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL1 = 7'b0000010,
        S_MUL2 = 7'b0000100,
        S_MIX  = 7'b0001000,
        S_FIN1 = 7'b0010000,
        S_FIN2 = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   emit_go;

    // The result register may be loaded once its previous request has left.
    assign emit_go = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = DP_LOAD;
                    state_next = S_MUL1;
                end
            end
            S_MUL1: begin
                cmd.op     = DP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                cmd.op     = DP_MUL2;
                state_next = S_MIX;
            end
            S_MIX: begin
                cmd.op     = DP_MIX;
                state_next = status.last ? S_FIN1 : S_IDLE;
            end
            S_FIN1: begin
                cmd.op     = DP_FIN1;
                state_next = S_FIN2;
            end
            S_FIN2: begin
                cmd.op     = DP_FIN2;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (emit_go) begin
                    cmd.op     = DP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ src/m3h_dp.sv @@
// Datapath for the MurmurHash3 key hasher: running hash, length, one shared multiplier.
// Depends on m3h_pkg for constants, helper functions and the command and status types.
module m3h_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  m3h_pkg::dp_cmd_t    cmd,
    output m3h_pkg::dp_status_t status,
    input  m3h_pkg::in_item_t   s_data,
    input  logic [31:0]         seed,
    input  logic [4:0]          index_bits,
    output m3h_pkg::out_item_t  m_data
);
    import m3h_pkg::*;

    logic [31:0] word_reg, word_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] len_reg, len_next;
    logic        in_key_reg, in_key_next;
    out_item_t   out_reg, out_next;

    logic [31:0] mul_a, mul_b, mul_p;
    logic [31:0] mixed, rot, fin_x, fin_h, bucket_mask;
    logic [2:0]  cnt_in;

    assign cnt_in = clamp_count(s_data.byte_count);
    assign mixed  = hash_reg ^ k_reg;
    assign rot    = rotl13(mixed);
    assign fin_x  = hash_reg ^ len_reg;
    assign fin_h  = k_reg ^ (k_reg >> 16);
    assign bucket_mask = ~(32'hFFFFFFFF << index_bits);

    // One multiplier serves both scramble products and both finalizer products.
    always_comb begin
        mul_a = word_reg;
        mul_b = MIX_C1;
        case (cmd.op)
            DP_MUL2: begin
                mul_a = rotl15(k_reg);
                mul_b = MIX_C2;
            end
            DP_FIN1: begin
                mul_a = fin_x ^ (fin_x >> 16);
                mul_b = FIN_C1;
            end
            DP_FIN2: begin
                mul_a = k_reg ^ (k_reg >> 13);
                mul_b = FIN_C2;
            end
            default: begin
                mul_a = word_reg;
                mul_b = MIX_C1;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        word_next   = word_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        k_next      = k_reg;
        hash_next   = hash_reg;
        len_next    = len_reg;
        in_key_next = in_key_reg;
        out_next    = out_reg;
        unique case (cmd.op)
            DP_NOP: ;
            DP_LOAD: begin
                word_next   = mask_word(s_data.key_word, cnt_in);
                cnt_next    = cnt_in;
                last_next   = s_data.last_word;
                in_key_next = 1'b1;
                // A word arriving outside a key opens a new one.
                if (!in_key_reg) begin
                    hash_next = (seed == 32'd0) ? DEFAULT_SEED : seed;
                    len_next  = 32'd0;
                end
            end
            DP_MUL1, DP_MUL2, DP_FIN1, DP_FIN2: begin
                k_next = mul_p;
            end
            DP_MIX: begin
                if (cnt_reg == FULL_WORD) begin
                    // Multiply by five as a shift and add.
                    hash_next = (rot << 2) + rot + MIX_ADD;
                end else if (cnt_reg != 3'd0) begin
                    hash_next = mixed;
                end
                len_next = len_reg + {29'd0, cnt_reg};
                if (last_reg) begin
                    in_key_next = 1'b0;
                end
            end
            DP_EMIT: begin
                out_next.hash_value   = fin_h;
                out_next.bucket_index = fin_h[30:0] & bucket_mask[30:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_key_reg <= 1'b0;
        end else begin
            in_key_reg <= in_key_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
        k_reg    <= k_next;
        hash_reg <= hash_next;
        len_reg  <= len_next;
        out_reg  <= out_next;
    end

    assign status.last = last_reg;
    assign m_data      = out_reg;

endmodule

@@ src/m3h_checker.sv @@
// Port-level checker for the MurmurHash3 key hasher, bound to the top level.
// Depends on m3h_pkg for the payload types.
module m3h_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input m3h_pkg::in_item_t    s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input m3h_pkg::out_item_t   m_data,
    input logic                 pready
);
    import m3h_pkg::*;

    // A waiting key word request keeps its payload until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("key word request changed while waiting");

    // A stalled result request keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result request changed while stalled");

    // Each accepted word occupies the block, which then drops its input ready.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after a request");

    // A result appears only at the end of finalizing, never straight out of idle.
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without finalizing");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("configuration port stalled");

endmodule

bind murmur3_32_key_hash m3h_checker u_m3h_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);
